>>> src/srle_pkg.sv
`timescale 1ns / 1ps

package srle_pkg;

    localparam logic [7:0]  MARK_BYTE         = 8'hED;
    localparam logic [7:0]  PAGE_LIMIT        = 8'd12;
    localparam logic [7:0]  PAGE_HIGH         = 8'd4;
    localparam logic [7:0]  PAGE_TOP          = 8'd5;
    localparam logic [7:0]  PAGE_SCREEN       = 8'd8;
    localparam logic [15:0] BASE_HIGH         = 16'h8000;
    localparam logic [15:0] BASE_TOP          = 16'hC000;
    localparam logic [15:0] BASE_SCREEN       = 16'h4000;
    localparam logic [3:0]  BLOCK_COUNT_RESET = 4'd3;

    // one byte of the block section
    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } in_item_t;

    // one fill command or status request
    typedef struct packed {
        logic [15:0] write_address;
        logic [7:0]  write_value;
        logic [7:0]  write_count;
        logic        all_done;
        logic        bad_page;
    } fill_t;

    // base address for a valid page number
    function automatic logic [15:0] page_base(input logic [7:0] page);
        logic [15:0] base;
        base = 16'h0000;
        if (page == PAGE_HIGH) base = BASE_HIGH;
        else if (page == PAGE_TOP) base = BASE_TOP;
        else if (page == PAGE_SCREEN) base = BASE_SCREEN;
        return base;
    endfunction

endpackage

>>> src/srle_ifs.sv
`timescale 1ns / 1ps

interface srle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;
    modport source (output valid, output in_byte, output restart, input ready);
    modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

interface srle_fill_if;
    logic        valid;
    logic        ready;
    logic [15:0] write_address;
    logic [7:0]  write_value;
    logic [7:0]  write_count;
    logic        all_done;
    logic        bad_page;
    modport source (output valid, output write_address, output write_value,
                    output write_count, output all_done, output bad_page, input ready);
    modport sink   (input valid, input write_address, input write_value,
                    input write_count, input all_done, input bad_page, output ready);
endinterface

interface srle_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] block_count;
    modport source (output valid, output block_count, input ready);
    modport sink   (input valid, input block_count, output ready);
endinterface

>>> src/srle_in_stage.sv
`timescale 1ns / 1ps

module srle_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  srle_pkg::in_item_t in_item,
    input  logic              advance,
    output logic              held_valid,
    output srle_pkg::in_item_t held_item
);
    import srle_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // slot frees when its byte moves on in the same cycle
    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> src/srle_parser.sv
`timescale 1ns / 1ps

module srle_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  srle_pkg::in_item_t item,
    input  logic [3:0]         block_count,
    output logic               has_result,
    output srle_pkg::fill_t    result
);
    import srle_pkg::*;

    typedef enum logic [2:0] {
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAGE,
        PH_BODY,
        PH_AFTER_MARK,
        PH_RUN_COUNT,
        PH_RUN_VALUE
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [15:0] remain_reg, remain_next, remain_cur, remain_dec;
    logic [15:0] wptr_reg, wptr_next, wptr_cur;
    logic [3:0]  blocks_reg, blocks_next, blocks_cur, blocks_inc;
    logic [7:0]  run_reg, run_next, run_cur;
    logic        fin_reg, fin_next, fin_cur;
    logic        end_check, seq_end, wr, done;
    logic [7:0]  b;

    always_comb
    begin
        b = item.in_byte;

        // restart clears the parser before this byte is taken
        phase_cur  = item.restart ? PH_LEN_LO : phase_reg;
        remain_cur = item.restart ? 16'h0000 : remain_reg;
        wptr_cur   = item.restart ? 16'h0000 : wptr_reg;
        blocks_cur = item.restart ? 4'd0 : blocks_reg;
        run_cur    = item.restart ? 8'd0 : run_reg;
        fin_cur    = item.restart ? 1'b0 : fin_reg;

        phase_next  = phase_cur;
        remain_next = remain_cur;
        wptr_next   = wptr_cur;
        blocks_next = blocks_cur;
        run_next    = run_cur;
        fin_next    = fin_cur;

        remain_dec = (remain_cur != 16'h0000) ? remain_cur - 16'd1 : remain_cur;
        blocks_inc = blocks_cur + 4'd1;

        end_check = 1'b0;
        seq_end   = 1'b0;
        wr        = 1'b0;
        done      = 1'b0;
        result    = '0;

        if (!fin_cur)
        begin
            unique case (phase_cur)
                PH_LEN_LO:
                begin
                    remain_next = {8'h00, b};
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    remain_next = {b, remain_cur[7:0]};
                    phase_next  = PH_PAGE;
                end
                PH_PAGE:
                begin
                    if (b >= PAGE_LIMIT)
                    begin
                        fin_next        = 1'b1;
                        result.bad_page = 1'b1;
                    end
                    else
                    begin
                        wptr_next  = page_base(b);
                        phase_next = PH_BODY;
                        // an empty block ends straight after its page byte
                        end_check  = (remain_cur == 16'h0000);
                    end
                end
                PH_BODY:
                begin
                    remain_next          = remain_dec;
                    wr                   = 1'b1;
                    result.write_address = wptr_cur;
                    result.write_value   = b;
                    result.write_count   = 8'd1;
                    wptr_next            = wptr_cur + 16'd1;
                    if (b == MARK_BYTE) phase_next = PH_AFTER_MARK;
                    else seq_end = 1'b1;
                end
                PH_AFTER_MARK:
                begin
                    remain_next = remain_dec;
                    if (b == MARK_BYTE)
                    begin
                        // run overwrites the lone mark just stored
                        wptr_next  = wptr_cur - 16'd1;
                        phase_next = PH_RUN_COUNT;
                    end
                    else
                    begin
                        wr                   = 1'b1;
                        result.write_address = wptr_cur;
                        result.write_value   = b;
                        result.write_count   = 8'd1;
                        wptr_next            = wptr_cur + 16'd1;
                        seq_end              = 1'b1;
                    end
                end
                PH_RUN_COUNT:
                begin
                    remain_next = remain_dec;
                    run_next    = b;
                    phase_next  = PH_RUN_VALUE;
                end
                PH_RUN_VALUE:
                begin
                    remain_next = remain_dec;
                    if (run_cur != 8'd0)
                    begin
                        wr                   = 1'b1;
                        result.write_address = wptr_cur;
                        result.write_value   = b;
                        result.write_count   = run_cur;
                        wptr_next            = wptr_cur + {8'h00, run_cur};
                    end
                    seq_end = 1'b1;
                end
                default:
                begin
                    phase_next = PH_LEN_LO;
                end
            endcase

            if (seq_end)
            begin
                phase_next = PH_BODY;
                end_check  = (remain_next == 16'h0000);
            end

            // block boundary; zero block count behaves as one
            if (end_check)
            begin
                phase_next  = PH_LEN_LO;
                blocks_next = blocks_inc;
                if (blocks_inc >= block_count || blocks_inc == 4'd0)
                begin
                    fin_next = 1'b1;
                    done     = 1'b1;
                end
            end
        end

        result.all_done = done;
        has_result      = wr || done || result.bad_page;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN_LO;
            remain_reg <= 16'h0000;
            wptr_reg   <= 16'h0000;
            blocks_reg <= 4'd0;
            run_reg    <= 8'd0;
            fin_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            wptr_reg   <= wptr_next;
            blocks_reg <= blocks_next;
            run_reg    <= run_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

>>> src/srle_out_stage.sv
`timescale 1ns / 1ps

module srle_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  srle_pkg::fill_t load_data,
    output logic            free,
    output logic            out_valid,
    input  logic            out_ready,
    output srle_pkg::fill_t out_data
);
    import srle_pkg::*;

    logic  valid_reg;
    fill_t data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

>>> src/snapshot_block_rle_decoder_core.sv
`timescale 1ns / 1ps

// snapshot memory-block decoder with mark-byte run-length expansion
//
// stream : one byte of the block section per request; restart marks the
//          first byte of the section and clears the parser before it is used
// fill   : fill commands (address, value, count); a request with count 0 is
//          status only and carries all_done or bad_page
// cfg    : block_count, taken whenever valid is high; write only while idle
//
// path    : a held byte is parsed when the output register is free; its result,
//           if any, is registered there at the same edge and drives fill
// rate    : one byte per cycle while fill is not held; the parser state loop
//           (phase, length, write pointer) closes through its own registers
// bytes with no result skip the output register but wait for it to be free
// stall   : while fill is held the result waits in the output register and
//           the input register still takes one more byte, then stream stalls
// reset   : clears parser state, both valid flags, block_count back to 3
module snapshot_block_rle_decoder_core (
    input  logic              clk,
    input  logic              rst_n,
    srle_in_if.sink           stream,
    srle_fill_if.source       fill,
    srle_cfg_if.sink          cfg
);
    import srle_pkg::*;

    in_item_t   in_item, held_item;
    fill_t      step_result, out_data;
    logic       held_valid, step, has_result, out_free, out_load;
    logic [3:0] block_count_reg;

    // configuration register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            block_count_reg <= cfg.block_count;
        end
    end

    assign in_item.in_byte = stream.in_byte;
    assign in_item.restart = stream.restart;

    // a held byte is parsed when the output register can take its result
    assign step     = held_valid && out_free;
    assign out_load = step && has_result;

    srle_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stream.valid),
        .in_ready   (stream.ready),
        .in_item    (in_item),
        .advance    (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    srle_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (held_item),
        .block_count (block_count_reg),
        .has_result  (has_result),
        .result      (step_result)
    );

    srle_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (step_result),
        .free      (out_free),
        .out_valid (fill.valid),
        .out_ready (fill.ready),
        .out_data  (out_data)
    );

    assign fill.write_address = out_data.write_address;
    assign fill.write_value   = out_data.write_value;
    assign fill.write_count   = out_data.write_count;
    assign fill.all_done      = out_data.all_done;
    assign fill.bad_page      = out_data.bad_page;

endmodule

>>> src/srle_checker.sv
`timescale 1ns / 1ps

module srle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        fill_valid,
    input logic        fill_ready,
    input logic [15:0] fill_write_address,
    input logic [7:0]  fill_write_value,
    input logic [7:0]  fill_write_count,
    input logic        fill_all_done,
    input logic        fill_bad_page
);

    // held request stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_valid && !fill_ready |=> fill_valid)
        else $error("fill request dropped while stalled");

    // held request keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_valid && !fill_ready |=> $stable(fill_write_address)
            && $stable(fill_write_value) && $stable(fill_write_count)
            && $stable(fill_all_done) && $stable(fill_bad_page))
        else $error("fill payload changed while stalled");

    // bad page is status only and never completes the section
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_valid && fill_bad_page |-> fill_write_count == 8'd0
            && fill_write_address == 16'h0000 && !fill_all_done)
        else $error("bad page request carries a fill");

    // an empty fill only exists as a status request
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_valid && fill_write_count == 8'd0 |-> fill_all_done || fill_bad_page)
        else $error("empty fill without status");

endmodule

bind snapshot_block_rle_decoder_core srle_checker u_srle_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .fill_valid         (fill.valid),
    .fill_ready         (fill.ready),
    .fill_write_address (fill.write_address),
    .fill_write_value   (fill.write_value),
    .fill_write_count   (fill.write_count),
    .fill_all_done      (fill.all_done),
    .fill_bad_page      (fill.bad_page)
);
